### rtl/cubic_bspline_point_evaluator_top_macros.svh
// Assertion macros for the cubic B-spline point evaluator checker.
// Clocked on i_clk; the plain form is disabled while i_rst_n is low.
`ifndef CUBIC_BSPLINE_POINT_EVALUATOR_TOP_MACROS_SVH
`define CUBIC_BSPLINE_POINT_EVALUATOR_TOP_MACROS_SVH

// Check a property outside of reset.
`define CBSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define CBSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/cbsp_pkg.sv
// Shared constants and types for the cubic B-spline point evaluator.
// No dependencies; used by cbsp_store and the top level.
package cbsp_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int STEPS_DEF      = 1000;
    localparam int COORD_W        = 16;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_EVAL  = 1'b1
    } t_action;

    // Four coordinates of one segment, entry j in slot 0.
    typedef logic [3:0][COORD_W-1:0] t_quad;

    typedef struct packed {
        logic               en;
        logic [7:0]         idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_store_wr;

    typedef struct packed {
        logic       en;
        logic [7:0] seg;
    } t_store_rd;

endpackage

### rtl/cbsp_store.sv
// Control point store: four banks by index modulo four, one write and one
// registered read per bank per cycle. Depends on cbsp_pkg.
module cbsp_store #(
    parameter int MAX_POINTS = cbsp_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  cbsp_pkg::t_store_wr i_wr,
    input  cbsp_pkg::t_store_rd i_rd,
    output cbsp_pkg::t_quad     o_px,
    output cbsp_pkg::t_quad     o_py
);

    localparam int ROWS   = (MAX_POINTS + 3) / 4;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WORD_W = 2 * cbsp_pkg::COORD_W;

    logic [15:0]       w_wr_row_full;
    logic [ADDR_W-1:0] w_wr_row;
    logic              w_wr_ok;
    logic [15:0]       w_rd_row_full [4];
    logic [ADDR_W-1:0] w_rd_row      [4];
    logic [WORD_W-1:0] r_q           [4];
    logic [1:0]        r_seg_lo;

    assign w_wr_row_full = 16'(i_wr.idx[7:2]);
    assign w_wr_row      = w_wr_row_full[ADDR_W-1:0];
    assign w_wr_ok       = i_wr.en && (32'(i_wr.idx) < MAX_POINTS);

    // Bank b holds entry seg+k where (seg+k) mod 4 == b; banks below seg's
    // low bits take the next row.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_rd_row_full[b] = 16'(i_rd.seg[7:2])
                             + ((2'(b) < i_rd.seg[1:0]) ? 16'd1 : 16'd0);
            w_rd_row[b]      = w_rd_row_full[b][ADDR_W-1:0];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [WORD_W-1:0] r_bank [ROWS];

        always_ff @(posedge i_clk) begin
            if (w_wr_ok && (i_wr.idx[1:0] == 2'(b))) begin
                r_bank[w_wr_row] <= {i_wr.x, i_wr.y};
            end
            if (i_rd.en) begin
                r_q[b] <= r_bank[w_rd_row[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_seg_lo <= i_rd.seg[1:0];
        end
    end

    // Rotate bank order back into segment order.
    always_comb begin
        logic [1:0] sel;
        sel = 2'd0;
        for (int k = 0; k < 4; k++) begin
            sel     = r_seg_lo + 2'(k);
            o_px[k] = r_q[sel][WORD_W-1:cbsp_pkg::COORD_W];
            o_py[k] = r_q[sel][cbsp_pkg::COORD_W-1:0];
        end
    end

endmodule

### rtl/cubic_bspline_point_evaluator_top.sv
// Uniform cubic B-spline point evaluator: an accepted evaluate item passes the
// stages and output register to its result, one item per cycle while not stalled;
// the four-bank point store gives all four points of a segment in one read, and
// every stage is elastic. Write items update the store at their accept edge and
// give no result. Synchronous active-low reset clears point_count and the pipeline
// valid bits; the point store is not cleared and holds garbage until written.
module cubic_bspline_point_evaluator_top #(
    parameter int MAX_POINTS = cbsp_pkg::MAX_POINTS_DEF,
    parameter int STEPS      = cbsp_pkg::STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_point_index,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic [9:0]  i_step_index,
    input  logic [7:0]  i_segment_index,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic        o_drawn,
    // configuration: point_count
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);

    // Pipeline stages after the accept edge; the output register follows.
    localparam int NST = 11;

    // t = floor(step * 2^16 / STEPS): multiply by a truncated reciprocal,
    // which lands on the quotient or one below it, then correct once.
    localparam int          RECIP_SH = 42;
    localparam logic [41:0] RECIP    = 42'((64'd1 << RECIP_SH) / STEPS);
    localparam logic [16:0] STEPS_C  = 17'(STEPS);

    // floor(v / 3) for v below 2^18 as (v * ceil(2^20 / 3)) >> 20.
    localparam logic [18:0] DIV3_M  = 19'd349526;
    localparam int          DIV3_SH = 20;

    // ------------------------------------------------------------------
    // Handshake and elastic enables
    // ------------------------------------------------------------------
    logic [1:NST] r_vld;
    logic [1:NST] w_en;
    logic         w_en_out;
    logic         r_out_valid;
    logic         w_accept;
    logic         w_eval_in;

    // A stage may load when it is empty or its successor moves too, so
    // bubbles collapse and input keeps flowing behind a stalled result.
    always_comb begin
        w_en_out   = !r_out_valid || !i_out_stall;
        w_en[NST]  = !r_vld[NST] || w_en_out;
        for (int k = NST - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall = !w_en[1];
    assign w_accept   = i_in_valid && w_en[1];
    assign w_eval_in  = i_in_valid && (i_action == cbsp_pkg::ACT_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_eval_in;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_en_out) begin
                r_out_valid <= r_vld[NST];
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [8:0] r_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 9'd0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    // Clamp the count to the store and check that j..j+3 lie below it.
    logic [31:0] w_cnt_eff;
    logic        w_drawn_in;

    always_comb begin
        w_cnt_eff  = (32'(r_point_count) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                            : 32'(r_point_count);
        w_drawn_in = (w_cnt_eff >= 32'd4)
                  && ((32'(i_segment_index) + 32'd3) < w_cnt_eff);
    end

    // ------------------------------------------------------------------
    // Point store: writes land at their accept edge and the read of an
    // evaluate item issues at its own accept edge, so a read always sees
    // every earlier write and no forwarding is needed.
    // ------------------------------------------------------------------
    cbsp_pkg::t_store_wr w_wr;
    cbsp_pkg::t_store_rd w_rd;
    cbsp_pkg::t_quad     w_px;
    cbsp_pkg::t_quad     w_py;

    always_comb begin
        w_wr.en  = w_accept && (i_action == cbsp_pkg::ACT_WRITE);
        w_wr.idx = i_point_index;
        w_wr.x   = i_point_x;
        w_wr.y   = i_point_y;
        w_rd.en  = w_en[1];
        w_rd.seg = i_segment_index;
    end

    cbsp_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk (i_clk),
        .i_wr  (w_wr),
        .i_rd  (w_rd),
        .o_px  (w_px),
        .o_py  (w_py)
    );

    // ------------------------------------------------------------------
    // Stage 1: reciprocal product; store data arrives registered here
    // ------------------------------------------------------------------
    logic [51:0] r1_prod;
    logic [9:0]  r1_step;
    logic        r1_drawn;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_prod  <= 52'(i_step_index) * 52'(RECIP);
            r1_step  <= i_step_index;
            r1_drawn <= w_drawn_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient estimate and its back-multiply
    // ------------------------------------------------------------------
    logic [25:0]     r2_q;
    logic [42:0]     r2_mq;
    logic [9:0]      r2_step;
    logic            r2_drawn;
    cbsp_pkg::t_quad r2_px, r2_py;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_q     <= r1_prod[51:26];
            r2_mq    <= 43'(r1_prod[51:26]) * 43'(STEPS_C);
            r2_step  <= r1_step;
            r2_drawn <= r1_drawn;
            r2_px    <= w_px;
            r2_py    <= w_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainder check, one correction step at most
    // ------------------------------------------------------------------
    logic [25:0]     r3_q;
    logic            r3_inc;
    logic            r3_drawn;
    cbsp_pkg::t_quad r3_px, r3_py;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_q     <= r2_q;
            r3_inc   <= (43'({r2_step, 16'h0000}) - r2_mq) >= 43'(STEPS_C);
            r3_drawn <= r2_drawn;
            r3_px    <= r2_px;
            r3_py    <= r2_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: t saturated to Q0.16 and u = 1 - t
    // ------------------------------------------------------------------
    logic [25:0]     w_tq;
    logic [15:0]     w_tsat;
    logic [15:0]     r4_t;
    logic [16:0]     r4_u;
    logic            r4_drawn;
    cbsp_pkg::t_quad r4_px, r4_py;

    always_comb begin
        w_tq   = r3_q + 26'(r3_inc);
        w_tsat = (w_tq > 26'd65535) ? 16'hFFFF : w_tq[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_t     <= w_tsat;
            r4_u     <= 17'h10000 - 17'(w_tsat);
            r4_drawn <= r3_drawn;
            r4_px    <= r3_px;
            r4_py    <= r3_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squares
    // ------------------------------------------------------------------
    logic [31:0]     r5_t2;
    logic [33:0]     r5_u2;
    logic [15:0]     r5_t;
    logic [16:0]     r5_u;
    logic            r5_drawn;
    cbsp_pkg::t_quad r5_px, r5_py;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_t2    <= 32'(r4_t) * 32'(r4_t);
            r5_u2    <= 34'(r4_u) * 34'(r4_u);
            r5_t     <= r4_t;
            r5_u     <= r4_u;
            r5_drawn <= r4_drawn;
            r5_px    <= r4_px;
            r5_py    <= r4_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: cubes, Q0.48
    // ------------------------------------------------------------------
    logic [47:0]     r6_t3;
    logic [50:0]     r6_u3;
    logic [31:0]     r6_t2;
    logic [15:0]     r6_t;
    logic            r6_drawn;
    cbsp_pkg::t_quad r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_t3    <= 48'(r5_t2) * 48'(r5_t);
            r6_u3    <= 51'(r5_u2) * 51'(r5_u);
            r6_t2    <= r5_t2;
            r6_t     <= r5_t;
            r6_drawn <= r5_drawn;
            r6_px    <= r5_px;
            r6_py    <= r5_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: basis numerators in Q0.48, shifted down by 2^33 so that only
    // a divide by three remains (floor of a floor keeps the result exact)
    // ------------------------------------------------------------------
    logic [52:0]     w_t3, w_t2s, w_ts, w_one;
    logic [52:0]     w_num1, w_num2;
    logic [17:0]     r7_v [4];
    logic            r7_drawn;
    cbsp_pkg::t_quad r7_px, r7_py;

    always_comb begin
        w_t3   = 53'(r6_t3);
        w_t2s  = 53'(r6_t2) << 16;
        w_ts   = 53'(r6_t) << 32;
        w_one  = 53'd1 << 48;
        // 3t^3 - 6t^2 + 4
        w_num1 = (w_t3 << 1) + w_t3 + (w_one << 2) - (w_t2s << 2) - (w_t2s << 1);
        // -3t^3 + 3t^2 + 3t + 1
        w_num2 = w_one + (w_t2s << 1) + w_t2s + (w_ts << 1) + w_ts
               - (w_t3 << 1) - w_t3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_v[0]  <= r6_u3[50:33];
            r7_v[1]  <= w_num1[50:33];
            r7_v[2]  <= w_num2[50:33];
            r7_v[3]  <= 18'(r6_t3[47:33]);
            r7_drawn <= r6_drawn;
            r7_px    <= r6_px;
            r7_py    <= r6_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: weights in Q1.16 by reciprocal divide by three
    // ------------------------------------------------------------------
    logic [36:0]     w_div3 [4];
    logic [16:0]     r8_w   [4];
    logic            r8_drawn;
    cbsp_pkg::t_quad r8_px, r8_py;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_div3[k] = 37'(r7_v[k]) * 37'(DIV3_M);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int k = 0; k < 4; k++) begin
                r8_w[k] <= w_div3[k][DIV3_SH+16:DIV3_SH];
            end
            r8_drawn <= r7_drawn;
            r8_px    <= r7_px;
            r8_py    <= r7_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: weight times point, eight multipliers
    // ------------------------------------------------------------------
    logic signed [33:0] r9_mx [4];
    logic signed [33:0] r9_my [4];
    logic               r9_drawn;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int k = 0; k < 4; k++) begin
                r9_mx[k] <= $signed({1'b0, r8_w[k]}) * $signed(r8_px[k]);
                r9_my[k] <= $signed({1'b0, r8_w[k]}) * $signed(r8_py[k]);
            end
            r9_drawn <= r8_drawn;
        end
    end

    // ------------------------------------------------------------------
    // Stages 10 and 11: two-level adder tree
    // ------------------------------------------------------------------
    logic signed [34:0] r10_sx [2];
    logic signed [34:0] r10_sy [2];
    logic               r10_drawn;
    logic signed [35:0] r11_sx, r11_sy;
    logic               r11_drawn;

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r10_sx[0] <= 35'(r9_mx[0]) + 35'(r9_mx[1]);
            r10_sx[1] <= 35'(r9_mx[2]) + 35'(r9_mx[3]);
            r10_sy[0] <= 35'(r9_my[0]) + 35'(r9_my[1]);
            r10_sy[1] <= 35'(r9_my[2]) + 35'(r9_my[3]);
            r10_drawn <= r9_drawn;
        end
        if (w_en[11]) begin
            r11_sx    <= 36'(r10_sx[0]) + 36'(r10_sx[1]);
            r11_sy    <= 36'(r10_sy[0]) + 36'(r10_sy[1]);
            r11_drawn <= r10_drawn;
        end
    end

    // ------------------------------------------------------------------
    // Output register: drop the Q16 fraction toward zero, force zero for
    // a segment outside the stored points
    // ------------------------------------------------------------------
    logic signed [35:0] w_adj_x, w_adj_y;
    logic signed [15:0] r_pixel_x, r_pixel_y;
    logic               r_drawn;

    always_comb begin
        w_adj_x = r11_sx + (r11_sx[35] ? 36'sd65535 : 36'sd0);
        w_adj_y = r11_sy + (r11_sy[35] ? 36'sd65535 : 36'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_pixel_x <= r11_drawn ? w_adj_x[31:16] : 16'sd0;
            r_pixel_y <= r11_drawn ? w_adj_y[31:16] : 16'sd0;
            r_drawn   <= r11_drawn;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_drawn     = r_drawn;

endmodule

### rtl/cbsp_checker.sv
// Port-level checker for the cubic B-spline point evaluator, bound to the top.
// Depends on cubic_bspline_point_evaluator_top_macros.svh.
`include "cubic_bspline_point_evaluator_top_macros.svh"

module cbsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_pixel_x,
    input logic [15:0] o_pixel_y,
    input logic        o_drawn
);

    // Reset empties the result register.
    `CBSP_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // An empty output register means every stage can move.
    `CBSP_ASSERT(a_no_stall_when_empty, !o_out_valid |-> !o_in_stall, "input stalled with no result waiting")

    // A segment outside the stored points gives a zero coordinate.
    `CBSP_ASSERT(a_undrawn_zero, o_out_valid && !o_drawn |-> o_pixel_x == 16'd0 && o_pixel_y == 16'd0, "undrawn result not zero")

    // Hold a stalled result.
    `CBSP_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_drawn), "stalled result changed")

endmodule

bind cubic_bspline_point_evaluator_top cbsp_checker u_cbsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pixel_x   (o_pixel_x),
    .o_pixel_y   (o_pixel_y),
    .o_drawn     (o_drawn)
);
